/* hdl/rcpo_pkg.sv */
// ----------------------------------------------------------------------------
// rcpo_pkg
// Shared types, codes and cosine table builder for the raised cosine
// phase oscillator.
// ----------------------------------------------------------------------------
package rcpo_pkg;

    // command codes
    typedef enum logic {
        CMD_ADVANCE = 1'b0,
        CMD_LOAD    = 1'b1
    } cmd_t;

    // configuration register indexes
    localparam logic [1:0] CFG_VAL_MIN    = 2'd0;
    localparam logic [1:0] CFG_VAL_MAX    = 2'd1;
    localparam logic [1:0] CFG_PHASE_STEP = 2'd2;

    localparam int CFG_INDEX_W = 2;
    localparam int VALUE_W     = 16;

    localparam logic signed [15:0] VAL_MIN_RST = 16'sd0;
    localparam logic signed [15:0] VAL_MAX_RST = 16'sd256;
    localparam int                 STEP_RST    = 256;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // first-quadrant cosine in Q1.15, m in [0, quarter]; Taylor series through x^12
    function automatic logic [15:0] quad_cos(input int unsigned m, input int unsigned tb);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] mag;
        logic [63:0] r;
        longint      sum;
        x   = (64'(m) * HALF_PI_Q30) >> (tb - 2);
        x2  = (x * x) >> 30;
        mag = 64'd1 << 30;
        sum = longint'(mag);
        mag = ((mag * x2) >> 30) / 64'd2;
        sum = sum - longint'(mag);
        mag = ((mag * x2) >> 30) / 64'd12;
        sum = sum + longint'(mag);
        mag = ((mag * x2) >> 30) / 64'd30;
        sum = sum - longint'(mag);
        mag = ((mag * x2) >> 30) / 64'd56;
        sum = sum + longint'(mag);
        mag = ((mag * x2) >> 30) / 64'd90;
        sum = sum - longint'(mag);
        mag = ((mag * x2) >> 30) / 64'd132;
        sum = sum + longint'(mag);
        if (sum < 0)
        begin
            sum = 0;
        end
        r = (64'(sum) + (64'd1 << 14)) >> 15;
        if (r > 64'd32767)
        begin
            r = 64'd32767;
        end
        return r[15:0];
    endfunction

    // full-turn cosine table entry k of 2^tb, by quadrant symmetry
    function automatic logic signed [15:0] table_entry(input int unsigned k,
                                                       input int unsigned tb);
        int unsigned quarter;
        int unsigned q;
        int unsigned r;
        logic [15:0] c;
        logic signed [15:0] e;
        quarter = 1 << (tb - 2);
        q = (k >> (tb - 2)) & 3;
        r = k & (quarter - 1);
        unique case (q)
            0:       begin c = quad_cos(r, tb);           e = $signed(c);  end
            1:       begin c = quad_cos(quarter - r, tb); e = -$signed(c); end
            2:       begin c = quad_cos(r, tb);           e = -$signed(c); end
            default: begin c = quad_cos(quarter - r, tb); e = $signed(c);  end
        endcase
        return e;
    endfunction

endpackage

/* hdl/rcpo_cmd_if.sv */
// ----------------------------------------------------------------------------
// rcpo_cmd_if
// Request channel: advance or load-phase command.
// ----------------------------------------------------------------------------
interface rcpo_cmd_if #(
    parameter int PHASE_W = 17
);
    logic               valid;
    logic               ready;
    logic               command;
    logic [PHASE_W-1:0] new_phase;

    modport source (output valid, output command, output new_phase, input ready);
    modport sink   (input valid, input command, input new_phase, output ready);
endinterface

/* hdl/rcpo_res_if.sv */
// ----------------------------------------------------------------------------
// rcpo_res_if
// Result channel: oscillator value and phase.
// ----------------------------------------------------------------------------
interface rcpo_res_if #(
    parameter int PHASE_W = 17
);
    logic               valid;
    logic               ready;
    logic signed [15:0] value;
    logic [PHASE_W-1:0] phase;

    modport source (output valid, output value, output phase, input ready);
    modport sink   (input valid, input value, input phase, output ready);
endinterface

/* hdl/rcpo_cfg_if.sv */
// ----------------------------------------------------------------------------
// rcpo_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rcpo_cfg_if #(
    parameter int DATA_W = 17
);
    logic              valid;
    logic              ready;
    logic [1:0]        index;
    logic [DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/raised_cosine_phase_oscillator.sv */
// ----------------------------------------------------------------------------
// raised_cosine_phase_oscillator
// Phase accumulator oscillator with a raised cosine output between two limits.
// ----------------------------------------------------------------------------
// Usage:
//   cmd : one request per item. command 0 adds phase_step to the phase (a sum
//         beyond a full turn of 2^PHASE_BITS resets the phase to zero) and
//         recomputes value = min + (max-min)*(cos+1)/2. command 1 loads
//         new_phase and keeps the last value.
//   res : one result per request: value (signed Q8.8) and the new phase.
//   cfg : register writes (0 val_min, 1 val_max, 2 phase_step), always ready.
//         Write only while no request is in flight; other indexes are dropped.
// Path: request to result through the request register, then the result register.
// Throughput: one request per cycle while results are taken. The phase
//   accumulator updates at request time (one add and compare); the table
//   lookup and 17x17 multiply sit between the request and result registers.
// Stall: with res.ready low, the result register holds and one more request
//   is taken into the request register; cmd.ready drops after that.
// Reset: phase 0, value 256, val_min 0, val_max 256, phase_step 256; both
//   pipeline registers empty.
// ----------------------------------------------------------------------------
module raised_cosine_phase_oscillator #(
    parameter int PHASE_BITS = 16,
    parameter int TABLE_BITS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    rcpo_cmd_if.sink    cmd,
    rcpo_res_if.source  res,
    rcpo_cfg_if.sink    cfg
);

    localparam int PW  = PHASE_BITS + 1;
    localparam int TBL = 1 << TABLE_BITS;
    localparam int SH  = PHASE_BITS - TABLE_BITS;

    // configuration registers
    logic signed [15:0] val_min_reg;
    logic signed [15:0] val_max_reg;
    logic [PW-1:0]      step_reg;

    // oscillator state
    logic [PW-1:0]      acc_reg;
    logic [PW-1:0]      acc_next;
    logic signed [15:0] held_reg;

    // request stage
    logic               s1_valid_reg;
    logic               s1_load_reg;
    logic [PW-1:0]      s1_phase_reg;

    // result stage
    logic               res_valid_reg;
    logic signed [15:0] res_value_reg;
    logic [PW-1:0]      res_phase_reg;
    logic signed [15:0] res_value_next;

    logic res_free;
    logic s1_move;
    logic cmd_take;
    logic cmd_load;
    logic [PW:0] step_sum;

    // result register is free when empty or being drained
    assign res_free  = !res_valid_reg || res.ready;
    assign s1_move   = s1_valid_reg && res_free;
    assign cmd.ready = !s1_valid_reg || res_free;
    assign cmd_take  = cmd.valid && cmd.ready;
    assign cmd_load  = (cmd.command == rcpo_pkg::CMD_LOAD);
    assign cfg.ready = 1'b1;

    assign res.valid = res_valid_reg;
    assign res.value = res_value_reg;
    assign res.phase = res_phase_reg;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_min_reg <= rcpo_pkg::VAL_MIN_RST;
            val_max_reg <= rcpo_pkg::VAL_MAX_RST;
            step_reg    <= PW'(rcpo_pkg::STEP_RST);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                rcpo_pkg::CFG_VAL_MIN:    val_min_reg <= $signed(cfg.data[15:0]);
                rcpo_pkg::CFG_VAL_MAX:    val_max_reg <= $signed(cfg.data[15:0]);
                rcpo_pkg::CFG_PHASE_STEP: step_reg    <= cfg.data[PW-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- phase accumulator ----------------
    // wrapping to zero: any sum past a full turn restarts at zero
    assign step_sum = {1'b0, acc_reg} + {1'b0, step_reg};

    always_comb
    begin
        if (cmd_load)
        begin
            acc_next = cmd.new_phase;
        end
        else if (step_sum > ((PW+1)'(1) << PHASE_BITS))
        begin
            acc_next = '0;
        end
        else
        begin
            acc_next = step_sum[PW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_take)
            begin
                acc_reg <= acc_next;
            end
            if (cmd_take)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            s1_load_reg  <= cmd_load;
            s1_phase_reg <= acc_next;
        end
    end

    // ---------------- cosine table ----------------
    logic signed [15:0]   cos_tab [TBL];
    logic [TABLE_BITS-1:0] tab_idx;

    for (genvar k = 0; k < TBL; k++)
    begin : g_tab
        localparam logic signed [15:0] ENTRY = rcpo_pkg::table_entry(k, TABLE_BITS);
        assign cos_tab[k] = ENTRY;
    end

    // index = phase truncated to TABLE_BITS fractional-turn bits
    if (SH >= 0)
    begin : g_idx_shr
        assign tab_idx = s1_phase_reg[SH +: TABLE_BITS];
    end
    else
    begin : g_idx_shl
        assign tab_idx = {s1_phase_reg[TABLE_BITS+SH-1:0], {(-SH){1'b0}}};
    end

    // ---------------- value ----------------
    logic signed [15:0] cos_val;
    logic [15:0]        cos_bias;
    logic signed [16:0] diff;
    logic signed [33:0] prod;
    logic signed [33:0] scaled;
    logic [15:0]        adv_value;

    assign cos_val   = cos_tab[tab_idx];
    assign cos_bias  = cos_val + 16'h8000;                 // c + 32768, unsigned
    assign diff      = {val_max_reg[15], val_max_reg} - {val_min_reg[15], val_min_reg};
    assign prod      = 34'(diff) * 34'($signed({1'b0, cos_bias}));
    assign scaled    = (prod + 34'sd32768) >>> 16;         // round half up
    assign adv_value = val_min_reg + scaled[15:0];

    assign res_value_next = s1_load_reg ? held_reg : $signed(adv_value);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            held_reg      <= rcpo_pkg::VAL_MAX_RST;
        end
        else
        begin
            if (s1_move)
            begin
                res_valid_reg <= 1'b1;
                held_reg      <= res_value_next;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            res_value_reg <= res_value_next;
            res_phase_reg <= s1_phase_reg;
        end
    end

endmodule

/* hdl/rcpo_checker.sv */
// ----------------------------------------------------------------------------
// rcpo_checker
// Port-level assertions for the raised cosine phase oscillator, bound to it.
// ----------------------------------------------------------------------------
module rcpo_checker #(
    parameter int PHASE_BITS = 16
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cmd_valid,
    input logic                  cmd_ready,
    input logic                  res_valid,
    input logic                  res_ready,
    input logic signed [15:0]    res_value,
    input logic [PHASE_BITS:0]   res_phase
);

    // requests taken but not yet delivered
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       in_take;
    logic       out_take;

    assign in_take  = cmd_valid && cmd_ready;
    assign out_take = res_valid && res_ready;

    always_comb
    begin
        count_next = count_reg;
        if (in_take && !out_take)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!in_take && out_take)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_value) && $stable(res_phase))
        else $error("result changed while stalled");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_ready |-> res_valid && !res_ready)
        else $error("request side stalled without a waiting result");

    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> count_reg != 2'd0)
        else $error("result without an outstanding request");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("more requests in flight than pipeline stages");

endmodule

bind raised_cosine_phase_oscillator rcpo_checker #(
    .PHASE_BITS (PHASE_BITS)
) u_rcpo_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_value (res.value),
    .res_phase (res.phase)
);
